// File: hdl/nearest_color_l1_search_assert.svh
// Assertion macros for the nearest-color search block.
// Each macro is empty when ASSERT_OFF is defined.
`ifndef NEAREST_COLOR_L1_SEARCH_ASSERT_SVH
`define NEAREST_COLOR_L1_SEARCH_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition must hold at every clock edge outside reset.
`define NCL1_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define NCL1_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`else

`define NCL1_ASSERT_ALWAYS(lbl, cond, msg)
`define NCL1_ASSERT_IMPLIES(lbl, ante, cons, msg)

`endif

`endif

// File: hdl/ncl1_pkg.sv
package ncl1_pkg;

   // Field widths
   localparam int CHAN_W = 8;
   localparam int DIST_W = 10;
   localparam int CFG_W  = 9;

   // Command codes
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Distance reported for an empty table
   localparam logic [DIST_W-1:0] EMPTY_DISTANCE = 10'd765;

   // One stored color, blue in the low byte
   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } color_type;

   typedef struct packed {
      logic              cmd;
      logic [7:0]        entry_index;
      logic [CHAN_W-1:0] chan_blue;
      logic [CHAN_W-1:0] chan_green;
      logic [CHAN_W-1:0] chan_red;
   } req_type;

   typedef struct packed {
      logic [7:0]        best_index;
      logic [DIST_W-1:0] best_distance;
   } rsp_type;

endpackage

// File: hdl/ncl1_ram.sv
module ncl1_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ncl1_dist.sv
module ncl1_dist
   import ncl1_pkg::*;
(
   input  color_type         query,
   input  color_type         entry,
   output logic [DIST_W-1:0] distance
);

   logic [CHAN_W-1:0] diff_b;
   logic [CHAN_W-1:0] diff_g;
   logic [CHAN_W-1:0] diff_r;

   // Absolute difference per channel
   always_comb begin
      diff_b = (query.blue  > entry.blue)  ? query.blue  - entry.blue  : entry.blue  - query.blue;
      diff_g = (query.green > entry.green) ? query.green - entry.green : entry.green - query.green;
      diff_r = (query.red   > entry.red)   ? query.red   - entry.red   : entry.red   - query.red;
   end

   // Sum of the three channel distances
   assign distance = DIST_W'(diff_b) + DIST_W'(diff_g) + DIST_W'(diff_r);

endmodule

// File: hdl/nearest_color_l1_search.sv
// Nearest-color search by L1 distance. A load request (cmd = 0) writes one
// color into the table; loads at entry_index >= MAX_TILES are dropped. A
// query request (cmd = 1) scans entries 0 .. n-1, with n = min(tile_count,
// MAX_TILES), reading one entry per cycle from the single read port of the
// table RAM through one shared distance unit, and returns the lowest-index
// entry with the smallest distance. req_stall stays high from acceptance of
// a query until its response is registered, also while a previous response
// waits on rsp_stall; n = 0 returns index 0, distance 765. Table entries
// must be loaded before a query reads them. The user must write tile_count
// through csr_wr_en/csr_wr_data only while the block is idle; it is unchecked.
module nearest_color_l1_search
   import ncl1_pkg::*;
#(
   parameter int MAX_TILES = 256
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   `include "nearest_color_l1_search_assert.svh"

   localparam int ADDR_W = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
   localparam int CNT_W  = $clog2(MAX_TILES + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type          state_ff,     state_in;
   logic [CFG_W-1:0]   tile_cnt_ff,  tile_cnt_in;
   logic [CNT_W-1:0]   n_ff,         n_in;
   logic [CNT_W-1:0]   idx_ff,       idx_in;
   logic               rd_pend_ff,   rd_pend_in;
   logic [ADDR_W-1:0]  rd_idx_ff,    rd_idx_in;
   color_type          query_ff,     query_in;
   logic [DIST_W-1:0]  best_dist_ff, best_dist_in;
   logic [ADDR_W-1:0]  best_idx_ff,  best_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff,  rsp_data_in;

   logic               req_fire;
   logic               ram_wr_en;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [23:0]        ram_rd_data;
   color_type          req_color;
   logic [DIST_W-1:0]  entry_dist;
   logic               rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   assign req_color.red   = req_data.chan_red;
   assign req_color.green = req_data.chan_green;
   assign req_color.blue  = req_data.chan_blue;

   // Table writes from load requests in range
   assign ram_wr_en   = req_fire && (req_data.cmd == CMD_LOAD)
                        && (32'(req_data.entry_index) < MAX_TILES);
   assign ram_wr_addr = ADDR_W'(req_data.entry_index);
   assign ram_rd_en   = (state_ff == ST_SCAN) && (idx_ff < n_ff);

   ncl1_ram #(
      .WIDTH (24),
      .DEPTH (MAX_TILES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (req_color),
      .rd_en   (ram_rd_en),
      .rd_addr (idx_ff[ADDR_W-1:0]),
      .rd_data (ram_rd_data)
   );

   ncl1_dist u_dist (
      .query    (query_ff),
      .entry    (color_type'(ram_rd_data)),
      .distance (entry_dist)
   );

   // Sequencer next state
   always_comb begin
      state_in     = state_ff;
      tile_cnt_in  = tile_cnt_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      rd_pend_in   = ram_rd_en;
      rd_idx_in    = idx_ff[ADDR_W-1:0];
      query_in     = query_ff;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         tile_cnt_in = csr_wr_data;
      end

      // Compare the entry read last cycle against the running best
      if (rd_pend_ff && (entry_dist < best_dist_ff)) begin
         best_dist_in = entry_dist;
         best_idx_in  = rd_idx_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire && (req_data.cmd == CMD_QUERY)) begin
               query_in     = req_color;
               idx_in       = '0;
               best_dist_in = EMPTY_DISTANCE;
               best_idx_in  = '0;
               if (32'(tile_cnt_ff) > MAX_TILES) begin
                  n_in = CNT_W'(MAX_TILES);
               end else begin
                  n_in = CNT_W'(tile_cnt_ff);
               end
               state_in = (tile_cnt_ff == '0) ? ST_FINISH : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ram_rd_en) begin
               idx_in = idx_ff + CNT_W'(1);
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.best_index    = 8'(best_idx_ff);
               rsp_data_in.best_distance = best_dist_ff;
               state_in                  = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tile_cnt_ff  <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         tile_cnt_ff  <= tile_cnt_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
         idx_ff       <= idx_in;
      end
      rd_idx_ff    <= rd_idx_in;
      query_ff     <= query_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   `NCL1_ASSERT_IMPLIES(a_rsp_from_finish, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "stray response")
   `NCL1_ASSERT_IMPLIES(a_scan_in_range, state_ff == ST_SCAN, idx_ff <= n_ff, "scan index past count")
   `NCL1_ASSERT_IMPLIES(a_read_only_in_scan, rd_pend_ff, $past(state_ff == ST_SCAN), "read outside scan")
   `NCL1_ASSERT_ALWAYS(a_dist_bound, best_dist_ff <= EMPTY_DISTANCE || state_ff == ST_IDLE, "bad distance")

endmodule
